// ===== rtl/core/jet_pkg.sv =====
// Shared types and constants for the Julia escape-time block.
package jet_pkg;

    // Fixed field widths
    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 16;
    localparam int VALUE_BITS = 32;
    localparam int STEP_BITS  = 31;
    localparam int INDEX_BITS = 3;

    // Configuration register indexes
    localparam logic [INDEX_BITS-1:0] REG_C_RE      = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_C_IM      = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_ORIGIN_RE = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_ORIGIN_IM = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_STEP      = 3'd4;
    localparam logic [INDEX_BITS-1:0] REG_MAX_ITER  = 3'd5;

    // Register reset values
    localparam logic signed [VALUE_BITS-1:0] RST_C_RE      = -32'sd42278584;
    localparam logic signed [VALUE_BITS-1:0] RST_C_IM      = -32'sd36238787;
    localparam logic signed [VALUE_BITS-1:0] RST_ORIGIN_RE = -32'sd268435456;
    localparam logic signed [VALUE_BITS-1:0] RST_ORIGIN_IM = -32'sd167772160;
    localparam logic [STEP_BITS-1:0]         RST_STEP      = 31'd335544;
    localparam logic [COUNT_BITS-1:0]        RST_MAX_ITER  = 16'd100;

    // Input word
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } jet_in_t;

    // Result word
    typedef struct packed {
        logic [COUNT_BITS-1:0] iteration_count;
        logic                  escaped;
    } jet_out_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_LOAD,
        ST_MUL,
        ST_TEST,
        ST_FINISH
    } jet_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic map_mul;
        logic load_z;
        logic mul;
        logic update;
        logic set_esc;
        logic out_load;
    } jet_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic at_limit;
        logic escape;
        logic out_busy;
    } jet_stat_t;

endpackage

// ===== rtl/core/jet_datapath.sv =====
// Datapath: config registers, pixel mapping, z iteration and result register.
module jet_datapath #(
    parameter int FRAC_BITS = 26
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [jet_pkg::INDEX_BITS-1:0]     cfg_index,
    input  logic [jet_pkg::VALUE_BITS-1:0]     cfg_wdata,
    input  jet_pkg::jet_in_t                   s_data,
    input  logic                               m_ready,
    output logic                               m_valid,
    output jet_pkg::jet_out_t                  m_data,
    input  jet_pkg::jet_cmd_t                  cmd,
    output jet_pkg::jet_stat_t                 stat
);

    localparam int VB = jet_pkg::VALUE_BITS;
    localparam int CB = jet_pkg::COUNT_BITS;
    // shifted product width
    localparam int PW = 2 * VB - FRAC_BITS;
    // pixel offset product width
    localparam int MW = jet_pkg::COORD_BITS + jet_pkg::STEP_BITS;
    // common sum width, wide enough for every sum and the escape bound
    localparam int SW0 = (PW + 2 > FRAC_BITS + 4) ? PW + 2 : FRAC_BITS + 4;
    localparam int SW  = (SW0 > MW + 2) ? SW0 : MW + 2;

    localparam logic signed [SW-1:0] SMAX = SW'(32'sh7fffffff);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
    localparam logic signed [SW-1:0] FOUR = SW'(4) <<< FRAC_BITS;

    function automatic logic signed [VB-1:0] sat32(input logic signed [SW-1:0] v);
        logic signed [VB-1:0] r;
        if (v > SMAX) begin
            r = SMAX[VB-1:0];
        end else if (v < SMIN) begin
            r = SMIN[VB-1:0];
        end else begin
            r = v[VB-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic signed [VB-1:0]            c_re_reg, c_im_reg, origin_re_reg, origin_im_reg;
    logic [jet_pkg::STEP_BITS-1:0]   step_reg;
    logic [CB-1:0]                   max_iter_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_re_reg      <= jet_pkg::RST_C_RE;
            c_im_reg      <= jet_pkg::RST_C_IM;
            origin_re_reg <= jet_pkg::RST_ORIGIN_RE;
            origin_im_reg <= jet_pkg::RST_ORIGIN_IM;
            step_reg      <= jet_pkg::RST_STEP;
            max_iter_reg  <= jet_pkg::RST_MAX_ITER;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                jet_pkg::REG_C_RE:      c_re_reg      <= cfg_wdata;
                jet_pkg::REG_C_IM:      c_im_reg      <= cfg_wdata;
                jet_pkg::REG_ORIGIN_RE: origin_re_reg <= cfg_wdata;
                jet_pkg::REG_ORIGIN_IM: origin_im_reg <= cfg_wdata;
                jet_pkg::REG_STEP:      step_reg      <= cfg_wdata[jet_pkg::STEP_BITS-1:0];
                jet_pkg::REG_MAX_ITER:  max_iter_reg  <= cfg_wdata[CB-1:0];
                default: ;
            endcase
        end
    end

    // Pixel capture and offset products
    jet_pkg::jet_in_t pix_reg;
    logic [MW-1:0]    off_x_reg, off_y_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pix_reg <= s_data;
        end
        if (cmd.map_mul) begin
            off_x_reg <= MW'(pix_reg.pixel_x) * MW'(step_reg);
            off_y_reg <= MW'(pix_reg.pixel_y) * MW'(step_reg);
        end
    end

    // Starting point sums
    logic signed [SW-1:0] start_re, start_im;
    assign start_re = SW'(origin_re_reg) + signed'(SW'(off_x_reg));
    assign start_im = SW'(origin_im_reg) + signed'(SW'(off_y_reg));

    // Squares and cross product, floor-shifted
    logic signed [VB-1:0]     zr_reg, zi_reg;
    logic signed [2*VB-1:0]   p_rr, p_ii, p_ri;
    logic signed [PW-1:0]     rr_reg, ii_reg, ri_reg;

    assign p_rr = (2*VB)'(zr_reg) * (2*VB)'(zr_reg);
    assign p_ii = (2*VB)'(zi_reg) * (2*VB)'(zi_reg);
    assign p_ri = (2*VB)'(zr_reg) * (2*VB)'(zi_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rr_reg <= PW'(p_rr >>> FRAC_BITS);
            ii_reg <= PW'(p_ii >>> FRAC_BITS);
            ri_reg <= PW'(p_ri >>> FRAC_BITS);
        end
    end

    // Escape test and update sums
    logic signed [SW-1:0] mag_sum, re_sum, im_sum;
    assign mag_sum = SW'(rr_reg) + SW'(ii_reg);
    assign re_sum  = SW'(rr_reg) - SW'(ii_reg) + SW'(c_re_reg);
    assign im_sum  = (SW'(ri_reg) <<< 1) + SW'(c_im_reg);

    // z, count and escape flag
    logic [CB-1:0] count_reg;
    logic          esc_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_z) begin
            zr_reg <= sat32(start_re);
            zi_reg <= sat32(start_im);
        end else if (cmd.update) begin
            zr_reg <= sat32(re_sum);
            zi_reg <= sat32(im_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            esc_reg   <= 1'b0;
        end else begin
            if (cmd.load_z) begin
                count_reg <= '0;
            end else if (cmd.update) begin
                count_reg <= count_reg + CB'(1);
            end
            if (cmd.load_z) begin
                esc_reg <= 1'b0;
            end else if (cmd.set_esc) begin
                esc_reg <= 1'b1;
            end
        end
    end

    // Result register: holds one word while the receiver stalls
    logic              out_valid_reg, out_valid_next;
    jet_pkg::jet_out_t out_data_reg;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg.iteration_count <= count_reg;
            out_data_reg.escaped         <= esc_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Status
    assign stat.at_limit = (count_reg >= max_iter_reg);
    assign stat.escape   = (mag_sum >= FOUR);
    assign stat.out_busy = out_valid_reg && !m_ready;

endmodule

// ===== rtl/core/jet_ctrl.sv =====
// Controller: sequences mapping, iteration and result hand-off.
module jet_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jet_pkg::jet_stat_t stat,
    output jet_pkg::jet_cmd_t  cmd
);

    jet_pkg::jet_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jet_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            jet_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = jet_pkg::ST_MAP;
                end
            end
            jet_pkg::ST_MAP:  state_next = jet_pkg::ST_LOAD;
            jet_pkg::ST_LOAD: state_next = jet_pkg::ST_MUL;
            jet_pkg::ST_MUL: begin
                state_next = stat.at_limit ? jet_pkg::ST_FINISH : jet_pkg::ST_TEST;
            end
            jet_pkg::ST_TEST: begin
                state_next = stat.escape ? jet_pkg::ST_FINISH : jet_pkg::ST_MUL;
            end
            jet_pkg::ST_FINISH: begin
                if (!stat.out_busy) begin
                    state_next = jet_pkg::ST_IDLE;
                end
            end
            default: state_next = jet_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            jet_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            jet_pkg::ST_MAP:  cmd.map_mul = 1'b1;
            jet_pkg::ST_LOAD: cmd.load_z  = 1'b1;
            jet_pkg::ST_MUL:  cmd.mul     = 1'b1;
            jet_pkg::ST_TEST: begin
                cmd.set_esc = stat.escape;
                cmd.update  = !stat.escape;
            end
            jet_pkg::ST_FINISH: cmd.out_load = !stat.out_busy;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/julia_escape_time.sv =====
// Top level of the Julia escape-time iterator.
//
// Input channel s_*: one pixel coordinate (pixel_x, pixel_y) per word.
// Result channel m_*: one word per pixel, the iteration count and an
// escaped flag that is set when |z|^2 reached 4 before the limit.
// Configuration: cfg_wr_en with cfg_index and cfg_wdata writes one
// register (c_re, c_im, origin_re, origin_im, pixel_step, max_iterations);
// write only while the block is idle.
// Each iteration runs a MUL state for the three registered 32x32
// products and then a TEST state for the escape compare and the
// saturating update. A new pixel is accepted the cycle after the
// previous result is loaded into the output register, so pixels are
// processed one at a time. The default iteration limit is 100.
// Reset returns the configuration registers to their defaults, clears
// the count and escape flag, returns the controller to idle and
// drops m_valid.
// A stalled receiver holds the result in the output register; the block
// then finishes at most one further pixel and waits to hand it over.
module julia_escape_time #(
    parameter int FRAC_BITS = 26
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [jet_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [jet_pkg::VALUE_BITS-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  jet_pkg::jet_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output jet_pkg::jet_out_t              m_data
);

    jet_pkg::jet_cmd_t  cmd;
    jet_pkg::jet_stat_t stat;

    jet_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    jet_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // An accepted pixel takes the controller out of idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice without processing");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid && !m_ready))
        else $error("result register overwritten while stalled");

    // z is never updated on an escaping iteration
    a_no_update_on_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> !stat.escape && !cmd.set_esc)
        else $error("z updated after escape");

endmodule

// ===== tb/julia_escape_time_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for julia_escape_time: predicts each pixel's iteration count and escaped flag and compares.
module julia_escape_time_tb;

    localparam int     FRAC         = 26;
    localparam int     ONE_Q        = 1 << FRAC;     // 1.0 in Q6.26
    localparam int     PHASE_PIXELS = 200;
    localparam int     PHASE_COUNT  = 6;
    localparam longint LIMIT_CYCLES = 4_000_000;

    // Indexes the block has no register behind; writes must be ignored
    localparam logic [jet_pkg::INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [jet_pkg::INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [jet_pkg::INDEX_BITS-1:0] cfg_index = '0;
    logic [jet_pkg::VALUE_BITS-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    jet_pkg::jet_in_t               s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    jet_pkg::jet_out_t              m_data;

    // Shadow copy of the configuration registers
    logic signed [jet_pkg::VALUE_BITS-1:0] sh_c_re      = jet_pkg::RST_C_RE;
    logic signed [jet_pkg::VALUE_BITS-1:0] sh_c_im      = jet_pkg::RST_C_IM;
    logic signed [jet_pkg::VALUE_BITS-1:0] sh_origin_re = jet_pkg::RST_ORIGIN_RE;
    logic signed [jet_pkg::VALUE_BITS-1:0] sh_origin_im = jet_pkg::RST_ORIGIN_IM;
    logic [jet_pkg::STEP_BITS-1:0]         sh_step      = jet_pkg::RST_STEP;
    logic [jet_pkg::COUNT_BITS-1:0]        sh_max_iter  = jet_pkg::RST_MAX_ITER;

    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 55;
    int          fail_count    = 0;
    longint      cycle_count   = 0;

    // Escape results predicted for accepted pixels, oldest first
    jet_pkg::jet_out_t pending_escapes[$];

    julia_escape_time #(
        .FRAC_BITS(FRAC)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Saturate to the signed 32-bit range
    function automatic longint clamp_q32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Escape-time iteration for one pixel under the shadow configuration
    function automatic jet_pkg::jet_out_t predict_escape(input jet_pkg::jet_in_t px);
        longint            zr;
        longint            zi;
        longint            rr;
        longint            ii;
        longint            ri;
        longint            four;
        int unsigned       n;
        jet_pkg::jet_out_t res;
        four = longint'(4) <<< FRAC;
        zr = clamp_q32(longint'(sh_origin_re) + longint'(px.pixel_x) * longint'(sh_step));
        zi = clamp_q32(longint'(sh_origin_im) + longint'(px.pixel_y) * longint'(sh_step));
        n = 0;
        while (n < sh_max_iter) begin
            rr = (zr * zr) >>> FRAC;
            ii = (zi * zi) >>> FRAC;
            if (rr + ii >= four) break;
            ri = (zr * zi) >>> FRAC;
            zr = clamp_q32(rr - ii + longint'(sh_c_re));
            zi = clamp_q32(2 * ri + longint'(sh_c_im));
            n++;
        end
        res.iteration_count = n[jet_pkg::COUNT_BITS-1:0];
        res.escaped         = (n < sh_max_iter);
        return res;
    endfunction

    // Receiver: random backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: each accepted word against the oldest prediction
    always @(posedge aclk) begin : check_results
        jet_pkg::jet_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_escapes.size() == 0) begin
                $error("result word with no pixel pending: count %0d escaped %0b",
                       m_data.iteration_count, m_data.escaped);
                fail_count++;
            end else begin
                want = pending_escapes.pop_front();
                if (m_data.iteration_count !== want.iteration_count) begin
                    $error("iteration_count mismatch: expected %0d, actual %0d",
                           want.iteration_count, m_data.iteration_count);
                    fail_count++;
                end
                if (m_data.escaped !== want.escaped) begin
                    $error("escaped mismatch: expected %0b, actual %0b",
                           want.escaped, m_data.escaped);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // One register write; the enable stays up for back-to-back writes
    task automatic write_reg(input logic [jet_pkg::INDEX_BITS-1:0] idx,
                             input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            jet_pkg::REG_C_RE:      sh_c_re      = data;
            jet_pkg::REG_C_IM:      sh_c_im      = data;
            jet_pkg::REG_ORIGIN_RE: sh_origin_re = data;
            jet_pkg::REG_ORIGIN_IM: sh_origin_im = data;
            jet_pkg::REG_STEP:      sh_step      = data[jet_pkg::STEP_BITS-1:0];
            jet_pkg::REG_MAX_ITER:  sh_max_iter  = data[jet_pkg::COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Full register set, plus junk to the unused indexes
    task automatic set_config(input logic [31:0] c_re_w, input logic [31:0] c_im_w,
                              input logic [31:0] ore_w, input logic [31:0] oim_w,
                              input logic [31:0] step_w, input logic [31:0] iter_w);
        write_reg(jet_pkg::REG_C_RE, c_re_w);
        write_reg(REG_SPARE_A, $urandom());
        write_reg(jet_pkg::REG_C_IM, c_im_w);
        write_reg(jet_pkg::REG_ORIGIN_RE, ore_w);
        write_reg(jet_pkg::REG_ORIGIN_IM, oim_w);
        write_reg(jet_pkg::REG_STEP, step_w);
        write_reg(REG_SPARE_B, $urandom());
        write_reg(jet_pkg::REG_MAX_ITER, iter_w);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Send one pixel word after a random gap; predict its result on acceptance
    task automatic send_pixel(input logic [jet_pkg::COORD_BITS-1:0] x,
                              input logic [jet_pkg::COORD_BITS-1:0] y);
        jet_pkg::jet_in_t px;
        px.pixel_x = x;
        px.pixel_y = y;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_escapes.push_back(predict_escape(px));
    endtask

    // Hold off the sender until every pending result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_escapes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Reset values, corners of the coordinate range, alternating bit patterns
    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd800, 12'd500);
        send_pixel(12'd900, 12'd450);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        wait_idle();
    endtask

    // Zero limit (upper data bits must be dropped) and a limit of one
    task automatic test_iteration_limit();
        set_config(jet_pkg::RST_C_RE, jet_pkg::RST_C_IM,
                   jet_pkg::RST_ORIGIN_RE, jet_pkg::RST_ORIGIN_IM,
                   32'h8000_0000 | 32'(jet_pkg::RST_STEP), 32'hFFFF_0000);
        send_pixel(12'd800, 12'd500);
        send_pixel(12'd4095, 12'd4095);
        wait_idle();
        set_config(jet_pkg::RST_C_RE, jet_pkg::RST_C_IM,
                   jet_pkg::RST_ORIGIN_RE, jet_pkg::RST_ORIGIN_IM,
                   32'(jet_pkg::RST_STEP), 32'h0001_0001);
        send_pixel(12'd800, 12'd500);
        send_pixel(12'd0, 12'd0);
        wait_idle();
    endtask

    // Zero step: every pixel at the origin; longest run and escape at the start
    task automatic test_zero_step();
        set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h0000_FFFF);
        send_pixel(12'd4095, 12'd4095);
        wait_idle();
        set_config(32'd0, 32'd0, 32'(3 * ONE_Q), 32'd0, 32'd0, 32'h0000_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_idle();
    endtask

    // Saturation of the start point and of the update, and the |z|^2 == 4 boundary
    task automatic test_saturation();
        set_config(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 32'hFFFF_FFFF, 32'd10);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd0);
        wait_idle();
        set_config(Q_MAX, Q_MIN, 32'd0, 32'd0, 32'd1, 32'd10);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_idle();
        set_config(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 32'd1, 32'd10);
        send_pixel(12'd4095, 12'd0);
        wait_idle();
        // c = -2 lands exactly on |z|^2 == 4; just inside it keeps iterating
        set_config(32'(-2 * ONE_Q), 32'd0, 32'd0, 32'd0, 32'd0, 32'd20);
        send_pixel(12'd0, 12'd0);
        wait_idle();
        set_config(32'(-2 * ONE_Q + 1), 32'd0, 32'd0, 32'd0, 32'd0, 32'd20);
        send_pixel(12'd0, 12'd0);
        wait_idle();
    endtask

    // Random phases: even ones frame the Julia region, odd ones are fully random
    task automatic test_random_julia();
        int unsigned span;
        logic [31:0] iter_w;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 55;
                end
                1: begin
                    send_idle_pct = 55;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            wait_idle();
            iter_w = {16'($urandom()), 16'($urandom_range(150, 1))};
            if (phase % 2 == 0) begin
                // window of about 4 x 4 units around zero, span pixels wide
                span = $urandom_range(600, 100);
                set_config(32'(int'($urandom_range(2 * ONE_Q)) - ONE_Q),
                           32'(int'($urandom_range(2 * ONE_Q)) - ONE_Q),
                           32'(-2 * ONE_Q + int'($urandom_range(ONE_Q / 4)) - ONE_Q / 8),
                           32'(-2 * ONE_Q + int'($urandom_range(ONE_Q / 4)) - ONE_Q / 8),
                           {1'($urandom()), 31'((4 * ONE_Q) / span)}, iter_w);
            end else begin
                span = 4096;
                set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), iter_w);
            end
            repeat (PHASE_PIXELS) begin
                if (phase % 2 == 0 && $urandom_range(99) < 75)
                    send_pixel(12'($urandom_range(span - 1)), 12'($urandom_range(span - 1)));
                else
                    send_pixel(12'($urandom()), 12'($urandom()));
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_iteration_limit();
        test_zero_step();
        test_saturation();
        test_random_julia();
        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
